/* sv/bppd_pkg.sv */
`default_nettype none
package bppd_pkg;

   localparam int PIXELS     = 16;
   localparam int PLANE_BITS = 8;
   localparam int COLOUR_W   = 4;
   localparam int CNT_W      = $clog2(PIXELS);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // display modes
   localparam logic [2:0] MODE_320_4A  = 3'd0;
   localparam logic [2:0] MODE_320_4B  = 3'd1;
   localparam logic [2:0] MODE_320_16  = 3'd2;
   localparam logic [2:0] MODE_320_16U = 3'd3;
   localparam logic [2:0] MODE_640_2A  = 3'd4;
   localparam logic [2:0] MODE_640_2B  = 3'd5;
   localparam logic [2:0] MODE_640_4   = 3'd6;
   localparam logic [2:0] MODE_640_4U  = 3'd7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL3  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP = 3'd5;

   typedef logic [COLOUR_W-1:0] colour_type;

   typedef struct packed {
      logic [2:0]           mode;
      colour_type [3:0]     palette;
      logic [1:0]           group;
   } cfg_type;

   // plane bits at one position, plane four down to plane one
   typedef logic [3:0] bits_type;

   typedef colour_type [PIXELS-1:0] pixels_type;

   typedef struct packed {
      logic free;   // emitter can take a new group this cycle
   } emit_stat_type;

   function automatic colour_type lookup(input cfg_type cfg, input logic [1:0] code);
      return cfg.palette[code];
   endfunction

   function automatic colour_type map16(input cfg_type cfg, input logic [3:0] code);
      colour_type res;
      if (code[3:2] == cfg.group) begin
         res = cfg.palette[code[1:0]];
      end else begin
         res = code;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* sv/bitplane_pixel_palette_decoder.sv */
`default_nettype none
// Bit-plane pixel decoder with palette. A request carries the four plane
// bytes of one video address and produces a group of sixteen IGRB pixels,
// one per clock on rsp_pixel_colour with rsp_valid high, the sixteenth
// marked by rsp_group_last. The receiver cannot stall: every pixel is shown
// for exactly one cycle. A request is taken when start is high and busy low.
// Sixteen lanes decode the whole group in the cycle the request is taken,
// using the mode and palette registers as they stand then; the group waits
// in a holding register and then goes to the output shifter. The shifter
// emits one pixel per clock, so requests are taken no faster than groups
// drain, and back-to-back groups come out with no gap. A first pixel passes
// the holding, shifter and output registers in turn when the block is idle.
// Registers are written through csr_valid/csr_ready (always ready); write
// them only while no group is in flight.
module bitplane_pixel_palette_decoder (
   input  wire                              clock,
   input  wire                              reset,
   // request
   input  wire                              start,
   output logic                             busy,
   input  wire [bppd_pkg::PLANE_BITS-1:0]   req_plane_one,
   input  wire [bppd_pkg::PLANE_BITS-1:0]   req_plane_two,
   input  wire [bppd_pkg::PLANE_BITS-1:0]   req_plane_three,
   input  wire [bppd_pkg::PLANE_BITS-1:0]   req_plane_four,
   // result
   output logic                             rsp_valid,
   output logic [bppd_pkg::COLOUR_W-1:0]    rsp_pixel_colour,
   output logic                             rsp_group_last,
   // configuration
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [bppd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [bppd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bppd_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   pixels_type     lane_pixels;
   pixels_type     pend_ff, pend_in;
   logic           pend_valid_ff, pend_valid_in;
   logic           accept;
   logic           load;
   emit_stat_type  emit_stat;
   colour_type     emit_colour;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE:  cfg_in.mode       = csr_wdata[2:0];
            CSR_PAL0:  cfg_in.palette[0] = csr_wdata[COLOUR_W-1:0];
            CSR_PAL1:  cfg_in.palette[1] = csr_wdata[COLOUR_W-1:0];
            CSR_PAL2:  cfg_in.palette[2] = csr_wdata[COLOUR_W-1:0];
            CSR_PAL3:  cfg_in.palette[3] = csr_wdata[COLOUR_W-1:0];
            CSR_GROUP: cfg_in.group      = csr_wdata[1:0];
            default:   cfg_in = cfg_ff;   // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ----------------------------------------------------------------- lanes
   // Lane k shows pixel k: 320-wide modes use plane bit k/2, 640-wide modes
   // use bit k%8 of the even planes for the first eight, odd planes after.
   for (genvar k = 0; k < PIXELS; k++) begin : g_lane
      localparam int WIDE = k / 2;
      localparam int POS  = k % PLANE_BITS;
      localparam logic ODD = (k >= PLANE_BITS);

      bppd_lane u_lane (
         .cfg       (cfg_ff),
         .wide_bits ({req_plane_four[WIDE], req_plane_three[WIDE],
                      req_plane_two[WIDE],  req_plane_one[WIDE]}),
         .pos_bits  ({req_plane_four[POS],  req_plane_three[POS],
                      req_plane_two[POS],   req_plane_one[POS]}),
         .odd       (ODD),
         .colour    (lane_pixels[k])
      );
   end

   // ---------------------------------------------------------- holding stage
   // Hold one decoded group until the shifter frees up; the shifter frees up
   // on the cycle it emits the last pixel, so groups run back to back.
   assign load   = pend_valid_ff && emit_stat.free;
   assign busy   = pend_valid_ff && !emit_stat.free;
   assign accept = start && !busy;

   always_comb begin
      pend_valid_in = accept || (pend_valid_ff && !load);
      pend_in       = accept ? lane_pixels : pend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      pend_ff <= pend_in;
   end

   // -------------------------------------------------------------- shifter
   bppd_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .load_pixels      (pend_ff),
      .stat             (emit_stat),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_colour (emit_colour),
      .rsp_group_last   (rsp_group_last)
   );

   assign rsp_pixel_colour = emit_colour;

endmodule
`default_nettype wire

/* sv/bppd_lane.sv */
`default_nettype none
module bppd_lane (
   input  wire bppd_pkg::cfg_type    cfg,
   input  wire bppd_pkg::bits_type   wide_bits,
   input  wire bppd_pkg::bits_type   pos_bits,
   input  wire                       odd,
   output bppd_pkg::colour_type      colour
);
   import bppd_pkg::*;

   logic [1:0] hi;
   logic [3:0] code16;

   always_comb begin
      hi = wide_bits[3:2];
      if ((cfg.mode == MODE_320_16U) && (hi == cfg.group)) begin
         code16 = {hi, hi};
      end else begin
         code16 = wide_bits;
      end
   end

   always_comb begin
      case (cfg.mode)
         MODE_320_4A:  colour = lookup(cfg, wide_bits[1:0]);
         MODE_320_4B:  colour = lookup(cfg, wide_bits[3:2]);
         MODE_320_16,
         MODE_320_16U: colour = map16(cfg, code16);
         MODE_640_2A:  colour = lookup(cfg, {1'b0, odd ? pos_bits[1] : pos_bits[0]});
         MODE_640_2B:  colour = lookup(cfg, {1'b0, odd ? pos_bits[3] : pos_bits[2]});
         MODE_640_4:   colour = lookup(cfg, odd ? {pos_bits[3], pos_bits[1]}
                                                : {pos_bits[2], pos_bits[0]});
         MODE_640_4U:  colour = lookup(cfg, odd ? {pos_bits[3], pos_bits[3]}
                                                : {pos_bits[2], pos_bits[2]});
         default:      colour = '0;
      endcase
   end

endmodule
`default_nettype wire

/* sv/bppd_emit.sv */
`default_nettype none
module bppd_emit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          load,
   input  wire bppd_pkg::pixels_type    load_pixels,
   output bppd_pkg::emit_stat_type      stat,
   output logic                         rsp_valid,
   output bppd_pkg::colour_type         rsp_pixel_colour,
   output logic                         rsp_group_last
);
   import bppd_pkg::*;

   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PIXELS - 1);

   logic              active_ff, active_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   pixels_type        shift_ff, shift_in;
   logic              valid_ff, valid_in;
   colour_type        colour_ff, colour_in;
   logic              last_ff, last_in;

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      valid_in  = active_ff;
      colour_in = shift_ff[0];
      last_in   = active_ff && (cnt_ff == LAST_CNT);
      if (active_ff) begin
         // advance one pixel
         shift_in = {COLOUR_W'(0), shift_ff[PIXELS-1:1]};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == LAST_CNT) begin
            active_in = 1'b0;
         end
      end
      if (load) begin
         active_in = 1'b1;
         cnt_in    = '0;
         shift_in  = load_pixels;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         valid_ff  <= valid_in;
      end
      shift_ff  <= shift_in;
      colour_ff <= colour_in;
      last_ff   <= last_in;
   end

   assign stat.free        = !active_ff || (cnt_ff == LAST_CNT);
   assign rsp_valid        = valid_ff;
   assign rsp_pixel_colour = colour_ff;
   assign rsp_group_last   = valid_ff && last_ff;

endmodule
`default_nettype wire

/* verif/tb_bitplane_pixel_palette_decoder.sv */
module tb_bitplane_pixel_palette_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import bppd_pkg::*;

   // Stop the run if nothing moves on any channel for this many cycles.
   localparam int WATCHDOG_LIMIT = 1000;
   // Let the pipeline settle this long once the last pixel has shown.
   localparam int SETTLE_CYCLES  = 4;
   // Longest pause the sender takes between two requests.
   localparam int MAX_GAP        = 20;
   // Only the first few mismatches get a report line.
   localparam int REPORT_LIMIT   = 10;

   // Indexes past the register list: the block must ignore them.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      colour_type colour;
      logic       is_last;
   } shown_pixel_type;

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   start           = 1'b0;
   logic                   busy;
   logic [PLANE_BITS-1:0]  req_plane_one   = '0;
   logic [PLANE_BITS-1:0]  req_plane_two   = '0;
   logic [PLANE_BITS-1:0]  req_plane_three = '0;
   logic [PLANE_BITS-1:0]  req_plane_four  = '0;
   logic                   rsp_valid;
   logic [COLOUR_W-1:0]    rsp_pixel_colour;
   logic                   rsp_group_last;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index       = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata       = '0;

   // Shadow copy of the register file, updated when a write is accepted.
   logic [2:0]             mode_shadow     = MODE_320_4A;
   colour_type             palette_shadow [4] = '{default: '0};
   logic [1:0]             group_shadow    = '0;

   // Pixels still owed by the block, oldest first.
   shown_pixel_type        pending_pixels [$];

   int                     fail_count      = 0;
   int                     quiet_cycles    = 0;
   int                     sender_idle_pct = 0;

   logic [2:0] all_modes [8] = '{MODE_320_4A, MODE_320_4B, MODE_320_16, MODE_320_16U,
                                 MODE_640_2A, MODE_640_2B, MODE_640_4, MODE_640_4U};

   bitplane_pixel_palette_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_plane_one    (req_plane_one),
      .req_plane_two    (req_plane_two),
      .req_plane_three  (req_plane_three),
      .req_plane_four   (req_plane_four),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_group_last   (rsp_group_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Pixel predictor
   // ---------------------------------------------------------------------

   // Route a 16-colour code through the palette when its high pair matches
   // the selected group; pass it through raw otherwise.
   function automatic colour_type group_colour(input logic [3:0] code);
      if (code[3:2] == group_shadow) begin
         return palette_shadow[code[1:0]];
      end
      return code;
   endfunction

   // Decode one fetched address into sixteen pixels under the current
   // shadow registers and append them to the pending list.
   function automatic void predict_group(input logic [7:0] p1, input logic [7:0] p2,
                                         input logic [7:0] p3, input logic [7:0] p4);
      int              w;
      int              p;
      logic            odd;
      logic [1:0]      hi;
      logic [3:0]      code;
      shown_pixel_type px;
      for (int k = 0; k < PIXELS; k++) begin
         w   = k >> 1;        // code index in 320-wide modes
         p   = k & 7;         // bit index in 640-wide modes
         odd = (k >= 8);      // second half reads the odd plane byte
         case (mode_shadow)
            MODE_320_4A: begin
               px.colour = palette_shadow[{p2[w], p1[w]}];
            end
            MODE_320_4B: begin
               px.colour = palette_shadow[{p4[w], p3[w]}];
            end
            MODE_320_16: begin
               px.colour = group_colour({p4[w], p3[w], p2[w], p1[w]});
            end
            MODE_320_16U: begin
               // A high pair equal to the group repeats itself in the low pair.
               hi = {p4[w], p3[w]};
               code = (hi == group_shadow) ? {hi, hi} : {hi, p2[w], p1[w]};
               px.colour = group_colour(code);
            end
            MODE_640_2A: begin
               px.colour = palette_shadow[{1'b0, odd ? p2[p] : p1[p]}];
            end
            MODE_640_2B: begin
               px.colour = palette_shadow[{1'b0, odd ? p4[p] : p3[p]}];
            end
            MODE_640_4: begin
               px.colour = palette_shadow[odd ? {p4[p], p2[p]} : {p3[p], p1[p]}];
            end
            default: begin
               // Undocumented 4-colour mode doubles the upper plane bit.
               px.colour = palette_shadow[odd ? {p4[p], p4[p]} : {p3[p], p3[p]}];
            end
         endcase
         px.is_last = (k == PIXELS - 1);
         pending_pixels.push_back(px);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Pixel checker: every strobed pixel must match the oldest one owed.
   // ---------------------------------------------------------------------

   task automatic report_failure(input string what);
      if (fail_count < REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, what);
      end
      fail_count++;
   endtask

   always @(posedge clock) begin
      shown_pixel_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            report_failure($sformatf("unexpected pixel colour %h last %b",
                                     rsp_pixel_colour, rsp_group_last));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_colour !== want.colour || rsp_group_last !== want.is_last) begin
               report_failure($sformatf(
                  "pixel mismatch: expected colour %h last %b, got colour %h last %b",
                  want.colour, want.is_last, rsp_pixel_colour, rsp_group_last));
            end
         end
      end
   end

   // Watchdog: count cycles in which no channel moves anything.
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1 ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_bitplane_pixel_palette_decoder: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Offer one request and hold it until taken. Start stays high on return
   // unless the sender decides to pause, so back-to-back calls never lower
   // and raise it in the same step.
   task automatic send_request(input logic [7:0] p1, input logic [7:0] p2,
                               input logic [7:0] p3, input logic [7:0] p4);
      start           <= 1'b1;
      req_plane_one   <= p1;
      req_plane_two   <= p2;
      req_plane_three <= p3;
      req_plane_four  <= p4;
      do @(posedge clock); while (busy !== 1'b0);
      predict_group(p1, p2, p3, p4);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
   endtask

   // Drop start and wait until every owed pixel has shown, then settle.
   task automatic drain_pixels;
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; csr_valid stays high for a following write.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_MODE:  mode_shadow       = data[2:0];
         CSR_PAL0:  palette_shadow[0] = data[3:0];
         CSR_PAL1:  palette_shadow[1] = data[3:0];
         CSR_PAL2:  palette_shadow[2] = data[3:0];
         CSR_PAL3:  palette_shadow[3] = data[3:0];
         CSR_GROUP: group_shadow      = data[1:0];
         default: ;
      endcase
   endtask

   // Load the whole register file with junk in the unused upper bits.
   task automatic program_registers(input logic [2:0] mode, input colour_type c0,
                                    input colour_type c1, input colour_type c2,
                                    input colour_type c3, input logic [1:0] grp);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      csr_write(CSR_MODE,  {junk[7:3], mode});
      junk = 8'($urandom_range(0, 255));
      csr_write(CSR_PAL0,  {junk[7:4], c0});
      junk = 8'($urandom_range(0, 255));
      csr_write(CSR_PAL1,  {junk[7:4], c1});
      junk = 8'($urandom_range(0, 255));
      csr_write(CSR_PAL2,  {junk[7:4], c2});
      junk = 8'($urandom_range(0, 255));
      csr_write(CSR_PAL3,  {junk[7:4], c3});
      junk = 8'($urandom_range(0, 255));
      csr_write(CSR_GROUP, {junk[7:2], grp});
      csr_valid <= 1'b0;
   endtask

   // Favor the all-zero and all-one bytes now and then.
   function automatic logic [7:0] random_plane;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return 8'h00;
      end else if (pick == 1) begin
         return 8'hff;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset registers: mode 0 with an all-zero palette paints black.
   task automatic test_reset_defaults;
      sender_idle_pct = 0;
      send_request(8'hff, 8'hff, 8'hff, 8'hff);
      send_request(8'h00, 8'h00, 8'h00, 8'h00);
      drain_pixels();
   endtask

   // Walk every mode with a distinct palette; the group moves along so the
   // 16-colour modes see both mapped and raw codes.
   task automatic test_each_mode;
      sender_idle_pct = 0;
      foreach (all_modes[m]) begin
         program_registers(all_modes[m], 4'h3, 4'ha, 4'h5, 4'hc, m[1:0]);
         send_request(8'ha5, 8'h3c, 8'h0f, 8'hf0);
         send_request(8'h96, 8'h55, 8'hcc, 8'h69);
         drain_pixels();
      end
   endtask

   // Register extremes, upper data bits and spare indexes.
   task automatic test_register_edges;
      sender_idle_pct = 0;
      // Upper bits must be dropped: all ones leaves each field at its max.
      csr_write(CSR_MODE,  8'hff);
      csr_write(CSR_PAL0,  8'hff);
      csr_write(CSR_PAL1,  8'hff);
      csr_write(CSR_PAL2,  8'hff);
      csr_write(CSR_PAL3,  8'hff);
      csr_write(CSR_GROUP, 8'hff);
      csr_valid <= 1'b0;
      send_request(8'h0f, 8'hf0, 8'h33, 8'hcc);
      drain_pixels();
      // Spare indexes must leave every register alone.
      csr_write(CSR_SPARE_LO, 8'h00);
      csr_write(CSR_SPARE_HI, 8'h00);
      csr_valid <= 1'b0;
      send_request(8'h5a, 8'ha5, 8'hff, 8'h00);
      drain_pixels();
      // Only upper bits set: every field drops to zero.
      csr_write(CSR_MODE,  8'hf8);
      csr_write(CSR_PAL0,  8'hf0);
      csr_write(CSR_PAL1,  8'hf0);
      csr_write(CSR_PAL2,  8'hf0);
      csr_write(CSR_PAL3,  8'hf0);
      csr_write(CSR_GROUP, 8'hfc);
      csr_valid <= 1'b0;
      send_request(8'hff, 8'h00, 8'haa, 8'h55);
      drain_pixels();
   endtask

   // Random planes under random settings; the sender pauses by idle_pct.
   task automatic test_random_traffic(input int idle_pct, input int count);
      int         chunk;
      int         sent;
      int         pause_at;
      logic [3:0] fill;
      sender_idle_pct = idle_pct;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(3) == 0) begin
            // Extreme settings: outermost mode and a flat palette.
            fill = $urandom_range(1) ? 4'hf : 4'h0;
            program_registers($urandom_range(1) ? MODE_640_4U : MODE_320_4A,
                              fill, fill, fill, fill,
                              $urandom_range(1) ? 2'd3 : 2'd0);
         end else begin
            program_registers(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
         end
         if ($urandom_range(3) == 0) begin
            csr_write($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                      8'($urandom_range(0, 255)));
            csr_valid <= 1'b0;
         end
         chunk    = $urandom_range(6, 12);
         pause_at = $urandom_range(1, chunk - 1);
         for (int i = 0; i < chunk && sent < count; i++) begin
            // Hold off once mid-chunk until the block has gone quiet.
            if (i == pause_at) begin
               drain_pixels();
            end
            send_request(random_plane(), random_plane(), random_plane(), random_plane());
            sent++;
         end
         drain_pixels();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_each_mode();
      test_register_edges();
      test_random_traffic(0, 26);
      test_random_traffic(49, 26);
      test_random_traffic(10, 27);

      drain_pixels();
      if (fail_count == 0 && pending_pixels.size() == 0) begin
         $display("tb_bitplane_pixel_palette_decoder: PASS");
      end else begin
         $display("tb_bitplane_pixel_palette_decoder: FAIL");
      end
      $finish;
   end

endmodule
